// ----- rtl/core/grd_pkg.sv -----
// Package for the GDSII record deframer: item struct, type codes,
// the record type to data type table and the value size lookup.
// No dependencies.
package grd_pkg;

	localparam int unsigned NUM_RTYPES  = 60;
	localparam logic [5:0]  RT_ENDLIB   = 6'd4;

	localparam logic [2:0] DT_NONE   = 3'd0;
	localparam logic [2:0] DT_FLAGS  = 3'd1;
	localparam logic [2:0] DT_INT16  = 3'd2;
	localparam logic [2:0] DT_INT32  = 3'd3;
	localparam logic [2:0] DT_REAL4  = 3'd4;
	localparam logic [2:0] DT_REAL8  = 3'd5;
	localparam logic [2:0] DT_STRING = 3'd6;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_RTYPE    = 2'd1;
	localparam logic [1:0] ERR_MISMATCH = 2'd2;
	localparam logic [1:0] ERR_LENGTH   = 2'd3;

	localparam logic [2:0] DTYPE_TABLE [NUM_RTYPES] = '{
		3'd2,3'd2,3'd6,3'd5,3'd0,3'd2,3'd6,3'd0,3'd0,3'd0,
		3'd0,3'd0,3'd0,3'd2,3'd2,3'd3,3'd3,3'd0,3'd6,3'd2,
		3'd0,3'd0,3'd2,3'd1,3'd0,3'd6,3'd1,3'd5,3'd5,3'd0,
		3'd0,3'd6,3'd6,3'd2,3'd2,3'd6,3'd6,3'd2,3'd1,3'd3,
		3'd0,3'd0,3'd2,3'd2,3'd6,3'd0,3'd2,3'd3,3'd3,3'd3,
		3'd2,3'd2,3'd1,3'd3,3'd2,3'd6,3'd0,3'd2,3'd6,3'd2
	};

	// one parsed item handed from front to back
	typedef struct packed {
		logic [5:0]  rtype;
		logic [2:0]  dtype;
		logic [63:0] value;
		logic        vld;
		logic [15:0] pos;
		logic        last;
		logic [31:0] count;
		logic [1:0]  err;
		logic        lend;
		logic        is_real;
	} grd_item_t;

	// bytes per value, modulo 8 (an eight-byte real reads as zero)
	function automatic logic [2:0] value_size(input logic [2:0] dt);
		logic [2:0] sz;
		unique case (dt)
			DT_FLAGS, DT_INT16: sz = 3'd2;
			DT_INT32, DT_REAL4: sz = 3'd4;
			DT_REAL8:           sz = 3'd0;
			DT_STRING:          sz = 3'd1;
			default:            sz = 3'd0;
		endcase
		return sz;
	endfunction

endpackage

// ----- rtl/core/grd_front.sv -----
// Front part of the deframer: header parsing, type checks and value assembly.
// Emits one grd_item_t per result into the queue. Depends on grd_pkg.
module grd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        in_byte,
	output logic              push,
	output grd_pkg::grd_item_t item
);
	import grd_pkg::*;

	typedef enum logic [4:0] {
		PH_LEN_HI  = 5'b00001,
		PH_LEN_LO  = 5'b00010,
		PH_RTYPE   = 5'b00100,
		PH_DTYPE   = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] len_q, len_d;
	logic [5:0]  rtype_q, rtype_d;
	logic [2:0]  dtype_q, dtype_d;
	logic [15:0] left_q, left_d;
	logic [2:0]  held_q, held_d;
	logic [63:0] asm_q, asm_d;
	logic [15:0] vcnt_q, vcnt_d;
	logic        sterm_q, sterm_d;
	logic        halted_q, halted_d;
	logic [31:0] recs_q, recs_d;
	logic [63:0] asm_new;
	logic [2:0]  held_new;
	logic        lend;

	// decode one byte
	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		rtype_d  = rtype_q;
		dtype_d  = dtype_q;
		left_d   = left_q;
		held_d   = held_q;
		asm_d    = asm_q;
		vcnt_d   = vcnt_q;
		sterm_d  = sterm_q;
		halted_d = halted_q;
		recs_d   = recs_q;
		push     = 1'b0;
		item     = '0;
		item.rtype = rtype_q;
		item.dtype = dtype_q;
		asm_new  = {asm_q[55:0], in_byte};
		held_new = held_q + 3'd1;
		lend     = (rtype_q == RT_ENDLIB);
		if (accept && !halted_q) begin
			unique case (phase_q)
				PH_LEN_HI: begin
					len_d   = {in_byte, 8'h00};
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_d[7:0] = in_byte;
					phase_d    = PH_RTYPE;
				end
				PH_RTYPE: begin
					if (in_byte >= 8'(NUM_RTYPES)) begin
						halted_d   = 1'b1;
						push       = 1'b1;
						item.rtype = in_byte[5:0];
						item.dtype = DT_NONE;
						item.err   = ERR_RTYPE;
					end else begin
						rtype_d = in_byte[5:0];
						phase_d = PH_DTYPE;
					end
				end
				PH_DTYPE: begin
					item.dtype = in_byte[2:0];
					if (in_byte != {5'b0, DTYPE_TABLE[rtype_q]}) begin
						halted_d = 1'b1;
						push     = 1'b1;
						item.err = ERR_MISMATCH;
					end else if (len_q < 16'd4) begin
						halted_d = 1'b1;
						push     = 1'b1;
						item.err = ERR_LENGTH;
					end else begin
						dtype_d = in_byte[2:0];
						left_d  = len_q - 16'd4;
						held_d  = '0;
						asm_d   = '0;
						vcnt_d  = '0;
						sterm_d = 1'b0;
						if (len_q == 16'd4) begin
							// empty payload: record ends on this byte
							if (recs_q != '1) recs_d = recs_q + 32'd1;
							push      = 1'b1;
							item.last = 1'b1;
							item.lend = lend;
							halted_d  = lend;
							phase_d   = PH_LEN_HI;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					if (dtype_q == DT_STRING) begin
						if (!sterm_q) begin
							if (in_byte == 8'h00) begin
								sterm_d = 1'b1;
							end else begin
								item.vld   = 1'b1;
								item.value = {56'b0, in_byte};
								item.pos   = vcnt_q;
							end
						end
						vcnt_d = vcnt_q + 16'd1;
					end else if (dtype_q != DT_NONE) begin
						if (held_new == value_size(dtype_q)) begin
							item.vld = 1'b1;
							item.pos = vcnt_q;
							vcnt_d   = vcnt_q + 16'd1;
							asm_d    = '0;
							held_d   = '0;
							case (dtype_q)
								DT_INT16: item.value = {{48{asm_new[15]}}, asm_new[15:0]};
								DT_INT32: item.value = {{32{asm_new[31]}}, asm_new[31:0]};
								DT_REAL4, DT_REAL8: begin
									item.value   = asm_new;
									item.is_real = 1'b1;
								end
								default: item.value = {48'b0, asm_new[15:0]};
							endcase
						end else begin
							asm_d  = asm_new;
							held_d = held_new;
						end
					end
					left_d = left_q - 16'd1;
					if (left_q == 16'd1) begin
						// final byte: close the record, drop any partial value
						if (recs_q != '1) recs_d = recs_q + 32'd1;
						item.last = 1'b1;
						item.lend = lend;
						halted_d  = lend;
						asm_d     = '0;
						held_d    = '0;
						phase_d   = PH_LEN_HI;
					end
					push = item.vld || item.last;
				end
				default: phase_d = PH_LEN_HI;
			endcase
		end
		item.count = recs_d;
	end

	// hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEN_HI;
			len_q    <= '0;
			rtype_q  <= '0;
			dtype_q  <= '0;
			left_q   <= '0;
			held_q   <= '0;
			asm_q    <= '0;
			vcnt_q   <= '0;
			sterm_q  <= 1'b0;
			halted_q <= 1'b0;
			recs_q   <= '0;
		end else begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			rtype_q  <= rtype_d;
			dtype_q  <= dtype_d;
			left_q   <= left_d;
			held_q   <= held_d;
			asm_q    <= asm_d;
			vcnt_q   <= vcnt_d;
			sterm_q  <= sterm_d;
			halted_q <= halted_d;
			recs_q   <= recs_d;
		end
	end

endmodule

// ----- rtl/core/grd_queue.sv -----
// Short item queue between the front and back parts.
// Depends on grd_pkg.
module grd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  grd_pkg::grd_item_t wr_item,
	input  logic               pop,
	output grd_pkg::grd_item_t rd_item,
	output logic               empty,
	output logic               full
);
	import grd_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	grd_item_t       mem_q [DEPTH];
	logic [PW-1:0]   wptr_q, rptr_q;
	logic [CW-1:0]   cnt_q;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CW'(DEPTH));
	assign rd_item = mem_q[rptr_q];

	// store item
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wr_item;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)  rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (!push && pop) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- rtl/core/grd_back.sv -----
// Back part: three-stage pipeline that converts base-16 excess-64 reals
// to binary64 and drives the output register. Depends on grd_pkg.
module grd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  grd_pkg::grd_item_t q_item,
	input  logic               q_empty,
	output logic               pop,
	input  logic               out_stall,
	output logic               out_valid,
	output grd_pkg::grd_item_t out_item
);
	import grd_pkg::*;

	logic        adv;
	logic        v_s1, v_s2, v_s3;
	grd_item_t   it_s1, it_s2, it_s3;
	logic [55:0] m_c;
	logic [5:0]  p_c;
	logic [5:0]  p_s1;
	logic [55:0] m_s1;
	logic [55:0] norm_s2;
	logic [10:0] bexp_s2;
	logic        zero_s2;
	logic        sign_s2;
	logic [11:0] bexp_c;
	logic [52:0] q_c;
	logic [2:0]  rem_c;
	logic        up_c;
	logic [53:0] qr_c;
	logic [63:0] real_c;
	grd_item_t   res_c;

	assign adv       = !v_s3 || !out_stall;
	assign pop       = adv && !q_empty;
	assign out_valid = v_s3;
	assign out_item  = it_s3;

	// find leading one of the mantissa
	always_comb begin
		m_c = (q_item.dtype == DT_REAL8) ? q_item.value[55:0] : {32'b0, q_item.value[23:0]};
		p_c = '0;
		for (int i = 0; i < 56; i++) begin
			if (m_c[i]) p_c = 6'(i);
		end
	end

	// exponent from the top byte: p + 4*(e - 64) - mbits + 1023
	always_comb begin
		if (it_s1.dtype == DT_REAL8)
			bexp_c = 12'd767 + {6'b0, p_s1} + {3'b0, it_s1.value[62:56], 2'b0} - 12'd56;
		else
			bexp_c = 12'd767 + {6'b0, p_s1} + {3'b0, it_s1.value[30:24], 2'b0} - 12'd24;
	end

	// round to nearest even and pack
	always_comb begin
		q_c    = norm_s2[55:3];
		rem_c  = norm_s2[2:0];
		up_c   = (rem_c > 3'd4) || (rem_c == 3'd4 && q_c[0]);
		qr_c   = {1'b0, q_c} + {53'b0, up_c};
		if (zero_s2)
			real_c = {sign_s2, 63'b0};
		else if (qr_c[53])
			real_c = {sign_s2, bexp_s2 + 11'd1, 52'b0};
		else
			real_c = {sign_s2, bexp_s2, qr_c[51:0]};
		res_c = it_s2;
		if (it_s2.is_real) res_c.value = real_c;
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1   <= q_item;
			m_s1    <= m_c;
			p_s1    <= p_c;
			it_s2   <= it_s1;
			sign_s2 <= (it_s1.dtype == DT_REAL8) ? it_s1.value[63] : it_s1.value[31];
			norm_s2 <= m_s1 << (6'd55 - p_s1);
			bexp_s2 <= bexp_c[10:0];
			zero_s2 <= (m_s1 == '0);
			it_s3   <= res_c;
		end
	end

endmodule

// ----- rtl/core/gdsii_record_deframer.sv -----
// GDSII record deframer: takes one byte per cycle while in_stall is low; results
// pass one queue write and three conversion stages to the output register.
// Sustained rate: one byte per cycle while in_stall is low; the queue absorbs output stalls until full.
// Reset clears parser state, queue pointers and pipeline valid bits.
// Depends on grd_pkg, grd_front, grd_queue, grd_back.
module gdsii_record_deframer #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  record_type,
	output logic [2:0]  data_type,
	output logic [63:0] item_value,
	output logic        value_valid,
	output logic [15:0] value_position,
	output logic        last_in_record,
	output logic [31:0] record_count,
	output logic [1:0]  error_code,
	output logic        library_end
);
	import grd_pkg::*;

	logic      accept, push, pop, q_empty, q_full;
	grd_item_t f_item, q_item, o_item;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	grd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (in_byte),
		.push    (push),
		.item    (f_item)
	);

	grd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (f_item),
		.pop     (pop),
		.rd_item (q_item),
		.empty   (q_empty),
		.full    (q_full)
	);

	grd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_item    (q_item),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_item  (o_item)
	);

	assign record_type    = o_item.rtype;
	assign data_type      = o_item.dtype;
	assign item_value     = o_item.value;
	assign value_valid    = o_item.vld;
	assign value_position = o_item.pos;
	assign last_in_record = o_item.last;
	assign record_count   = o_item.count;
	assign error_code     = o_item.err;
	assign library_end    = o_item.lend;

endmodule

// ----- rtl/core/grd_checker.sv -----
// Port-level checks for the GDSII record deframer, bound to the top level.
// Depends on gdsii_record_deframer ports and grd_pkg.
module grd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] item_value,
	input logic        value_valid,
	input logic [15:0] value_position,
	input logic        last_in_record,
	input logic [1:0]  error_code,
	input logic        library_end
);
	import grd_pkg::*;

	// hold a stalled item
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(item_value))
		else $error("stalled item changed");

	// no value means zero value and position
	a_novalue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !value_valid |-> item_value == 64'd0 && value_position == 16'd0)
		else $error("value fields set without a value");

	// library end only closes a record
	a_lend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && library_end |-> last_in_record && error_code == ERR_NONE)
		else $error("library end without record end");

	// error items are neither values nor record ends
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> !value_valid && !last_in_record)
		else $error("error item carries a value");

endmodule

bind gdsii_record_deframer grd_checker u_grd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.item_value     (item_value),
	.value_valid    (value_valid),
	.value_position (value_position),
	.last_in_record (last_in_record),
	.error_code     (error_code),
	.library_end    (library_end)
);
